/* hw/rtl/tlpa_pkg.sv */
package tlpa_pkg;

  localparam int PIX_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int ACC_W      = 22;
  localparam int FRAC_W     = 12;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int HALF_LSB   = 2048;

  localparam int DEFAULT_MAX_SAMPLES = 1048576;
  localparam int FRAME_SAMPLES_RST   = 1048576;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic signed [GAIN_W-1:0] ACCEL_GAIN_RST = 16'sh1000;
  localparam logic signed [GAIN_W-1:0] DECAY_GAIN_RST = 16'sh0000;

  localparam logic signed [ACC_W-1:0] ACC_HIGH = 22'sh0FF000;
  localparam logic signed [ACC_W-1:0] ACC_LOW  = 22'sh200000;
  localparam logic [PIX_W-1:0]        PIX_MAX  = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_GAIN    = 2'd0,
    REG_DECAY_GAIN    = 2'd1,
    REG_FRAME_SAMPLES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  wen;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

/* hw/rtl/tlpa_if.sv */
interface tlpa_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [tlpa_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface tlpa_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlpa_pkg::PIX_W-1:0] pixel_out;
  logic                       frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

/* hw/rtl/tlpa_queue.sv */
module tlpa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlpa_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/tlpa_front.sv */
module tlpa_front #(
  parameter int MAX_SAMPLES = tlpa_pkg::DEFAULT_MAX_SAMPLES,
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int QW = AW + tlpa_pkg::PIX_W + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  tlpa_pkg::cfg_wr_t cfg,
  tlpa_pix_in_if.sink       pix_in,
  output logic              q_push,
  output logic [QW-1:0]     q_data,
  input  logic              q_full
);

  import tlpa_pkg::*;

  localparam int CW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
  localparam int RST_SAMPLES =
    (MAX_SAMPLES < FRAME_SAMPLES_RST) ? MAX_SAMPLES : FRAME_SAMPLES_RST;

  logic [AW-1:0] sample_index;
  logic [AW-1:0] last_pos;
  logic [AW-1:0] last_pos_next;
  logic          first_frame;
  logic [CW-1:0] fs_ext;
  logic          accept;
  logic          is_last;

  assign fs_ext  = CW'(cfg.data);
  assign accept  = pix_in.valid && !q_full;
  assign is_last = (sample_index == last_pos);

  assign pix_in.ready = !q_full;
  assign q_push       = accept;
  assign q_data       = {first_frame, is_last, pix_in.pixel_in, sample_index};

  // frame size of zero acts as one, oversize clamps to the store depth
  always_comb begin
    priority if (fs_ext == '0) begin
      last_pos_next = '0;
    end else if (fs_ext > CW'(MAX_SAMPLES)) begin
      last_pos_next = AW'(MAX_SAMPLES - 1);
    end else begin
      last_pos_next = AW'(fs_ext - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      last_pos     <= AW'(RST_SAMPLES - 1);
      first_frame  <= 1'b1;
    end else if (cfg.wen && (cfg.index == REG_FRAME_SAMPLES)) begin
      sample_index <= '0;
      last_pos     <= last_pos_next;
      first_frame  <= 1'b1;
    end else if (accept) begin
      if (is_last) begin
        sample_index <= '0;
        first_frame  <= 1'b0;
      end else begin
        sample_index <= sample_index + 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/tlpa_back.sv */
module tlpa_back #(
  parameter int MAX_SAMPLES = tlpa_pkg::DEFAULT_MAX_SAMPLES,
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int QW = AW + tlpa_pkg::PIX_W + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  tlpa_pkg::cfg_wr_t cfg,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [QW-1:0]     q_data,
  tlpa_pix_out_if.source    pix_out
);

  import tlpa_pkg::*;

  localparam int PD_W  = ACC_W + GAIN_W;
  localparam int PG_W  = PIX_W + 1 + GAIN_W;
  localparam int SUM_W = PD_W + 1;
  localparam int Q_W   = ACC_W + 1 - FRAC_W;

  logic signed [GAIN_W-1:0] accel_gain;
  logic signed [GAIN_W-1:0] decay_gain;

  logic signed [ACC_W-1:0]  mem [MAX_SAMPLES];
  logic signed [ACC_W-1:0]  rd_acc;

  logic [AW-1:0]            q_pos;
  logic [PIX_W-1:0]         q_pixel;
  logic                     q_last;
  logic                     q_first;

  logic                     s1_valid;
  logic [AW-1:0]            s1_pos;
  logic [PIX_W-1:0]         s1_pixel;
  logic                     s1_first;
  logic                     s1_last;

  logic                     s2_valid;
  logic [AW-1:0]            s2_pos;
  logic                     s2_last;
  logic signed [PD_W-1:0]   s2_prod_d;
  logic signed [PG_W-1:0]   s2_prod_g;

  logic                     wr_valid;
  logic [AW-1:0]            wr_pos;
  logic signed [ACC_W-1:0]  wr_acc;

  logic                     s3_valid;
  logic                     s3_last;
  logic signed [ACC_W-1:0]  s3_acc;

  logic                     s3_take;
  logic                     s2_move;
  logic                     s2_take;
  logic                     hazard;
  logic                     s1_move;
  logic                     s1_take;

  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [PG_W-1:0]   prod_g;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  new_acc;
  logic signed [ACC_W:0]    out_sum;
  logic signed [Q_W-1:0]    out_q;

  assign q_pos   = q_data[AW-1:0];
  assign q_pixel = q_data[AW +: PIX_W];
  assign q_last  = q_data[AW + PIX_W];
  assign q_first = q_data[AW + PIX_W + 1];

  // stage handshakes; an item stalls in s1 while its predecessor on the
  // same position is still being computed in s2
  assign s3_take = !s3_valid || pix_out.ready;
  assign s2_move = s2_valid && s3_take;
  assign s2_take = !s2_valid || s3_take;
  assign hazard  = s1_valid && !s1_first && s2_valid && (s2_pos == s1_pos);
  assign s1_move = s1_valid && !hazard && s2_take;
  assign s1_take = !s1_valid || s1_move;
  assign q_pop   = !q_empty && s1_take;

  // operand select: first frame loads the pixel, else newest written value
  always_comb begin
    priority if (s1_first) begin
      acc_sel = $signed({{(ACC_W - PIX_W - FRAC_W){1'b0}}, s1_pixel, {FRAC_W{1'b0}}});
    end else if (wr_valid && (wr_pos == s1_pos)) begin
      acc_sel = wr_acc;
    end else begin
      acc_sel = rd_acc;
    end
  end

  assign prod_d = acc_sel * decay_gain;
  assign prod_g = $signed({1'b0, s1_pixel}) * accel_gain;

  assign sum = SUM_W'(s2_prod_d) + (SUM_W'(s2_prod_g) <<< FRAC_W) + SUM_W'(HALF_LSB);
  assign rnd = sum >>> FRAC_W;

  always_comb begin
    priority if (rnd > SUM_W'(ACC_HIGH)) begin
      new_acc = ACC_HIGH;
    end else if (rnd < SUM_W'(ACC_LOW)) begin
      new_acc = ACC_LOW;
    end else begin
      new_acc = ACC_W'(rnd);
    end
  end

  assign out_sum = (ACC_W + 1)'(s3_acc) + (ACC_W + 1)'(HALF_LSB);
  assign out_q   = Q_W'(out_sum >>> FRAC_W);

  always_comb begin
    priority if (out_q < 0) begin
      pix_out.pixel_out = '0;
    end else if (out_q > $signed(Q_W'(PIX_MAX))) begin
      pix_out.pixel_out = PIX_MAX;
    end else begin
      pix_out.pixel_out = PIX_W'(out_q);
    end
  end

  assign pix_out.frame_end = s3_last;
  assign pix_out.valid     = s3_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_acc <= mem[q_pos];
    end
    if (s2_move) begin
      mem[s2_pos] <= new_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pos   <= q_pos;
      s1_pixel <= q_pixel;
      s1_first <= q_first;
      s1_last  <= q_last;
    end
    if (s1_move) begin
      s2_pos    <= s1_pos;
      s2_last   <= s1_last;
      s2_prod_d <= prod_d;
      s2_prod_g <= prod_g;
    end
    if (s2_move) begin
      wr_pos  <= s2_pos;
      wr_acc  <= new_acc;
      s3_acc  <= new_acc;
      s3_last <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      wr_valid   <= 1'b0;
      accel_gain <= ACCEL_GAIN_RST;
      decay_gain <= DECAY_GAIN_RST;
    end else begin
      if (s1_take) begin
        s1_valid <= q_pop;
      end
      if (s2_take) begin
        s2_valid <= s1_move;
      end
      if (s3_take) begin
        s3_valid <= s2_move;
      end
      if (s2_move) begin
        wr_valid <= 1'b1;
      end
      if (cfg.wen && (cfg.index == REG_ACCEL_GAIN)) begin
        accel_gain <= $signed(cfg.data[GAIN_W-1:0]);
      end
      if (cfg.wen && (cfg.index == REG_DECAY_GAIN)) begin
        decay_gain <= $signed(cfg.data[GAIN_W-1:0]);
      end
    end
  end

endmodule

/* hw/rtl/temporal_leaky_pixel_accumulator.sv */
// Per-pixel temporal leaky accumulator. Samples arrive in raster order on
// pix_in; each one updates its position's accumulator in the frame store
// as acc*decay_gain + pixel*accel_gain (Q4.12 gains, 12 fraction bits,
// clamped to -512..255) and pix_out returns it rounded and saturated to
// 8 bits, with frame_end on the last sample of a frame. One item is taken
// per clock while the input queue has room and pix_out does not stall; a
// frame of a single sample runs slower, since each update then waits in s1
// for the multiply-accumulate of the previous one in s2. The store is a
// single-port-write, single-port-read memory of MAX_SAMPLES words needing
// no clearing after reset: the first frame after reset or after a write of
// frame_samples loads every position before reading it.
module temporal_leaky_pixel_accumulator #(
  parameter int MAX_SAMPLES = tlpa_pkg::DEFAULT_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [tlpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlpa_pkg::CFG_DATA_W-1:0] cfg_data,
  tlpa_pix_in_if.sink                    pix_in,
  tlpa_pix_out_if.source                 pix_out
);

  import tlpa_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int QW = AW + PIX_W + 2;

  cfg_wr_t       cfg;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_pop_data;
  logic          q_empty;

  assign cfg.wen   = cfg_wen;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tlpa_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pix_in (pix_in),
    .q_push (q_push),
    .q_data (q_push_data),
    .q_full (q_full)
  );

  tlpa_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  tlpa_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_pop_data),
    .pix_out (pix_out)
  );

endmodule
